>>> sv/tdmf_pkg.sv
// Package: widths, codes and payload types of the table-driven Mealy machine.
package tdmf_pkg;

    localparam int STATE_BITS  = 4;
    localparam int SYMBOL_BITS = 4;
    localparam int OUTPUT_BITS = 8;
    localparam int NUM_STATES  = 1 << STATE_BITS;
    localparam int TABLE_BITS  = STATE_BITS + SYMBOL_BITS;
    localparam int TABLE_DEPTH = 1 << TABLE_BITS;

    typedef enum logic [1:0] {
        CMD_STEP    = 2'd0,
        CMD_LOAD    = 2'd1,
        CMD_RESTART = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_STATE  = 2'd1,
        ST_NO_SYMBOL = 2'd2
    } t_status;

    typedef enum logic {
        CTRL_IDLE,
        CTRL_EXEC
    } t_ctrl_state;

    typedef struct packed {
        t_cmd                   command;
        logic [STATE_BITS-1:0]  src_state;
        logic [SYMBOL_BITS-1:0] symbol;
        logic [STATE_BITS-1:0]  dst_state;
        logic [OUTPUT_BITS-1:0] entry_value;
    } t_cmd_item;

    typedef struct packed {
        logic [OUTPUT_BITS-1:0] out_value;
        t_status                status;
        logic [STATE_BITS-1:0]  present_state;
    } t_result_item;

    typedef struct packed {
        logic [STATE_BITS-1:0]  dest_state;
        logic [OUTPUT_BITS-1:0] value;
    } t_entry;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;
        logic finish;
    } t_ctrl_cmd;

endpackage

>>> sv/table_driven_mealy_fsm.sv
// Top level: programmable Mealy state machine with a loadable transition table.
//
//  channel   | signals                        | handshake
//  ----------+--------------------------------+-------------------------------
//  command   | start, busy, i_item            | taken when start && !busy
//  result    | o_done, o_result               | one-cycle strobe, no stall
//  config    | i_cfg_wr_en, i_cfg_wr_data     | written when i_cfg_wr_en
//
// For each item, the accept edge reads the 256-entry table at
// {present state, symbol}, and the edge that ends the execute state updates
// the state and loads the result register; o_done rises with the result, in
// the cycle when busy is low again and a new item may be accepted.
// Synchronous reset clears valid bits, state flags, the result strobe and the start
// and present state registers. Results cannot be held off by the receiver.
module table_driven_mealy_fsm
    import tdmf_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  t_cmd_item             i_item,
    input  logic                  i_cfg_wr_en,
    input  logic [STATE_BITS-1:0] i_cfg_wr_data,
    output logic                  o_done,
    output t_result_item          o_result
);

    t_ctrl_cmd ctrl_cmd;

    tdmf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_cmd   (ctrl_cmd)
    );

    tdmf_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (ctrl_cmd),
        .i_item        (i_item),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_done        (o_done),
        .o_result      (o_result)
    );

`ifndef SYNTHESIS
    // An accepted item makes the block busy next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    // A busy cycle is followed by exactly one result strobe
    a_busy_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> (o_done && !busy))
        else $error("result strobe missing after busy cycle");

    // A strobe never appears without a preceding busy cycle
    a_done_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result strobe without an item");

    // A failed lookup returns a zero value
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_result.status != ST_OK)) |-> (o_result.out_value == '0))
        else $error("failed lookup returned a nonzero value");
`endif

endmodule

>>> sv/tdmf_ctrl.sv
// Controller: sequences each item through lookup and result cycles.
module tdmf_ctrl
    import tdmf_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    output t_ctrl_cmd o_cmd
);

    t_ctrl_state r_state;
    t_ctrl_state n_state;

    // Hold the controller state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= CTRL_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Advance on start, return to idle after the execute state
    always_comb begin
        n_state      = r_state;
        o_cmd.accept = 1'b0;
        o_cmd.finish = 1'b0;
        busy         = 1'b0;
        case (r_state)
            CTRL_IDLE: begin
                if (start) begin
                    o_cmd.accept = 1'b1;
                    n_state      = CTRL_EXEC;
                end
            end
            CTRL_EXEC: begin
                busy         = 1'b1;
                o_cmd.finish = 1'b1;
                n_state      = CTRL_IDLE;
            end
            default: begin
                n_state = CTRL_IDLE;
            end
        endcase
    end

endmodule

>>> sv/tdmf_dp.sv
// Datapath: transition table, valid flags, present state and result register.
module tdmf_dp
    import tdmf_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_ctrl_cmd             i_cmd,
    input  t_cmd_item             i_item,
    input  logic                  i_cfg_wr_en,
    input  logic [STATE_BITS-1:0] i_cfg_wr_data,
    output logic                  o_done,
    output t_result_item          o_result
);

    t_entry                  mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0]  r_valid;
    logic [NUM_STATES-1:0]   r_has;
    logic [STATE_BITS-1:0]   r_start;
    logic [STATE_BITS-1:0]   r_state;
    logic [STATE_BITS-1:0]   n_state;
    t_cmd                    r_cmd;
    t_entry                  r_rd_data;
    logic                    r_hit_valid;
    logic                    r_hit_has;
    logic                    r_done;
    t_result_item            r_result;
    t_result_item            n_result;
    logic [TABLE_BITS-1:0]   rd_idx;
    logic [TABLE_BITS-1:0]   wr_idx;
    logic                    do_load;

    assign rd_idx  = {r_state, i_item.symbol};
    assign wr_idx  = {i_item.src_state, i_item.symbol};
    assign do_load = i_cmd.accept && (i_item.command == CMD_LOAD);

    // Table memory: write on load, registered read at accept
    always_ff @(posedge i_clk) begin
        if (do_load) begin
            mem[wr_idx] <= '{dest_state: i_item.dst_state, value: i_item.entry_value};
        end
        if (i_cmd.accept) begin
            r_rd_data <= mem[rd_idx];
        end
    end

    // Valid bits and per-state flags, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_has   <= '0;
        end else if (do_load) begin
            r_valid[wr_idx]            <= 1'b1;
            r_has[i_item.src_state]    <= 1'b1;
        end
    end

    // Capture command and lookup flags of the accepted item
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_cmd       <= i_item.command;
            r_hit_valid <= r_valid[rd_idx];
            r_hit_has   <= r_has[r_state];
        end
    end

    // Resolve the item
    always_comb begin
        n_state  = r_state;
        n_result = '{out_value: '0, status: ST_OK, present_state: r_state};
        case (r_cmd)
            CMD_STEP: begin
                if (!r_hit_has) begin
                    n_result.status = ST_NO_STATE;
                end else if (!r_hit_valid) begin
                    n_result.status = ST_NO_SYMBOL;
                end else begin
                    n_state            = r_rd_data.dest_state;
                    n_result.out_value = r_rd_data.value;
                end
            end
            CMD_RESTART: begin
                n_state = r_start;
            end
            default: begin
                n_state = r_state;
            end
        endcase
        n_result.present_state = n_state;
    end

    // Hold start state, present state and result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= '0;
            r_state <= '0;
            r_done  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_start <= i_cfg_wr_data;
            end
            if (i_cmd.finish) begin
                r_state <= n_state;
            end
            r_done <= i_cmd.finish;
        end
    end

    // Register the result item
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_result <= n_result;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

>>> dv/table_driven_mealy_fsm_tb.sv
// Testbench: table-driven Mealy state machine, directed table then random checks.
`timescale 1ns / 1ps

module table_driven_mealy_fsm_tb;
    import tdmf_pkg::*;

    // Command code the block must ignore
    localparam logic [1:0] CMD_UNUSED  = 2'd3;
    localparam int         STALL_LIMIT = 2000;
    localparam int         PHASES      = 5;
    localparam int         PHASE_ITEMS = 250;
    localparam int         DIR_ROWS    = 16;

    typedef struct packed {
        t_cmd_item    item;
        logic         typed;
        t_result_item want;
    } t_dir_row;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    t_cmd_item             cmd_item;
    logic                  cfg_wr_en;
    logic [STATE_BITS-1:0] cfg_wr_data;
    logic                  done;
    t_result_item          result;

    // Machine image kept alongside the block
    logic                   entry_ok   [TABLE_DEPTH];
    logic [STATE_BITS-1:0]  entry_dest [TABLE_DEPTH];
    logic [OUTPUT_BITS-1:0] entry_out  [TABLE_DEPTH];
    logic                   state_used [NUM_STATES];
    logic [STATE_BITS-1:0]  mach_state;
    logic [STATE_BITS-1:0]  restart_state;

    t_result_item pending_results[$];
    t_dir_row     dir_rows[DIR_ROWS];
    bit           idle_on;
    int unsigned  mismatch_cnt  = 0;
    int unsigned  items_sent;
    int unsigned  results_seen  = 0;
    int unsigned  cfg_writes;
    int unsigned  status_cnt[4] = '{default: 0};
    int unsigned  stall_cycles;

    table_driven_mealy_fsm uut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .start         (start),
        .busy          (busy),
        .i_item        (cmd_item),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .o_done        (done),
        .o_result      (result)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic t_cmd_item mk_item(logic [1:0] op, logic [3:0] frm, logic [3:0] sym,
                                          logic [3:0] nxt, logic [7:0] val);
        t_cmd_item it;
        it.command     = t_cmd'(op);
        it.src_state   = frm;
        it.symbol      = sym;
        it.dst_state   = nxt;
        it.entry_value = val;
        return it;
    endfunction

    function automatic t_result_item mk_result(logic [7:0] val, t_status st, logic [3:0] ps);
        t_result_item r;
        r.out_value     = val;
        r.status        = st;
        r.present_state = ps;
        return r;
    endfunction

    // Apply one item to the machine image and return the result it produces
    function automatic t_result_item mealy_predict(t_cmd_item it);
        t_result_item          r;
        logic [1:0]            op;
        logic [TABLE_BITS-1:0] ix;
        op = it.command;
        r.out_value = '0;
        r.status    = ST_OK;
        case (op)
            CMD_LOAD: begin
                ix = {it.src_state, it.symbol};
                entry_ok[ix]   = 1'b1;
                entry_dest[ix] = it.dst_state;
                entry_out[ix]  = it.entry_value;
                state_used[it.src_state] = 1'b1;
            end
            CMD_RESTART: begin
                mach_state = restart_state;
            end
            CMD_STEP: begin
                ix = {mach_state, it.symbol};
                if (!state_used[mach_state]) begin
                    r.status = ST_NO_STATE;
                end else if (!entry_ok[ix]) begin
                    r.status = ST_NO_SYMBOL;
                end else begin
                    r.out_value = entry_out[ix];
                    mach_state  = entry_dest[ix];
                end
            end
            default: ;
        endcase
        r.present_state = mach_state;
        return r;
    endfunction

    // Mostly well-formed traffic on a small state/symbol set, with some noise
    function automatic t_cmd_item rand_item();
        int unsigned pick;
        logic [1:0]  op;
        logic [3:0]  frm;
        logic [3:0]  sym;
        logic [3:0]  nxt;
        pick = $urandom_range(99);
        frm  = ($urandom_range(19) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(11));
        nxt  = ($urandom_range(19) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(11));
        sym  = ($urandom_range(4) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(3));
        if (pick < 22) begin
            op = CMD_LOAD;
            if ($urandom_range(1) == 0) frm = mach_state;
        end else if (pick < 84) begin
            op = CMD_STEP;
        end else if (pick < 94) begin
            op = CMD_RESTART;
        end else begin
            op  = CMD_UNUSED;
            frm = 4'($urandom_range(15));
            nxt = 4'($urandom_range(15));
        end
        return mk_item(op, frm, sym, nxt, 8'($urandom_range(255)));
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("%0t: mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
        mismatch_cnt++;
    endtask

    // Drive one item from a falling edge; return at the falling edge after acceptance
    task automatic send_item(input t_cmd_item it, input logic typed, input t_result_item want);
        t_result_item pred;
        while (idle_on && $urandom_range(99) < 29) begin
            start <= 1'b0;
            @(negedge clk);
        end
        start    <= 1'b1;
        cmd_item <= it;
        do @(posedge clk); while (busy);
        pred = mealy_predict(it);
        pending_results.insert(pending_results.size(), typed ? want : pred);
        items_sent++;
        @(negedge clk);
    endtask

    // Hold off new items until every result is back, then let the block settle
    task automatic drain_results();
        start <= 1'b0;
        @(negedge clk);
        while (pending_results.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_start_state(input logic [STATE_BITS-1:0] val);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= val;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        restart_state = val;
        cfg_writes++;
        @(negedge clk);
    endtask

    // Check each result strobe against the oldest pending result
    always @(posedge clk) begin
        t_result_item want;
        if (rst_n && done) begin
            results_seen++;
            status_cnt[result.status]++;
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", result, 0);
            end else begin
                want = pending_results.pop_front();
                if (result.out_value !== want.out_value)
                    report_mismatch("out_value", result.out_value, want.out_value);
                if (result.status !== want.status)
                    report_mismatch("status", result.status, want.status);
                if (result.present_state !== want.present_state)
                    report_mismatch("present_state", result.present_state,
                                    want.present_state);
            end
        end
    end

    // Stop the run if nothing moves for too long
    always @(posedge clk) begin
        if (!rst_n || (start && !busy) || done) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no progress in %0d cycles", STALL_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        start        = 1'b0;
        cmd_item     = '0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = '0;
        rst_n        = 1'b0;
        idle_on      = 1'b1;
        items_sent   = 0;
        cfg_writes   = 0;
        mach_state    = '0;
        restart_state = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            entry_ok[i]   = 1'b0;
            entry_dest[i] = '0;
            entry_out[i]  = '0;
        end
        for (int i = 0; i < NUM_STATES; i++) state_used[i] = 1'b0;

        // Directed rows: reset state, extremes, every command and error code
        dir_rows[0]  = '{mk_item(CMD_STEP, 4'h0, 4'h0, 4'h0, 8'h00), 1'b1,
                         mk_result(8'h00, ST_NO_STATE, 4'h0)};
        dir_rows[1]  = '{mk_item(CMD_RESTART, 4'h0, 4'h0, 4'h0, 8'h00), 1'b1,
                         mk_result(8'h00, ST_OK, 4'h0)};
        dir_rows[2]  = '{mk_item(CMD_LOAD, 4'h0, 4'h5, 4'hF, 8'hFF), 1'b1,
                         mk_result(8'h00, ST_OK, 4'h0)};
        dir_rows[3]  = '{mk_item(CMD_STEP, 4'h0, 4'h3, 4'h0, 8'h00), 1'b1,
                         mk_result(8'h00, ST_NO_SYMBOL, 4'h0)};
        dir_rows[4]  = '{mk_item(CMD_STEP, 4'hF, 4'h5, 4'hF, 8'hFF), 1'b1,
                         mk_result(8'hFF, ST_OK, 4'hF)};
        dir_rows[5]  = '{mk_item(CMD_STEP, 4'h0, 4'h5, 4'h0, 8'h00), 1'b1,
                         mk_result(8'h00, ST_NO_STATE, 4'hF)};
        dir_rows[6]  = '{mk_item(CMD_LOAD, 4'hF, 4'hF, 4'h0, 8'h00), 1'b0, '0};
        dir_rows[7]  = '{mk_item(CMD_LOAD, 4'hF, 4'h0, 4'h7, 8'hA5), 1'b0, '0};
        dir_rows[8]  = '{mk_item(CMD_STEP, 4'h0, 4'hF, 4'h0, 8'h00), 1'b1,
                         mk_result(8'h00, ST_OK, 4'h0)};
        dir_rows[9]  = '{mk_item(CMD_UNUSED, 4'hF, 4'hF, 4'hF, 8'hFF), 1'b1,
                         mk_result(8'h00, ST_OK, 4'h0)};
        dir_rows[10] = '{mk_item(CMD_LOAD, 4'h0, 4'h5, 4'h3, 8'h5A), 1'b0, '0};
        dir_rows[11] = '{mk_item(CMD_STEP, 4'h0, 4'h5, 4'h0, 8'h00), 1'b0, '0};
        dir_rows[12] = '{mk_item(CMD_STEP, 4'h0, 4'h0, 4'h0, 8'h00), 1'b1,
                         mk_result(8'h00, ST_NO_STATE, 4'h3)};
        dir_rows[13] = '{mk_item(CMD_LOAD, 4'h3, 4'hA, 4'hF, 8'h01), 1'b0, '0};
        dir_rows[14] = '{mk_item(CMD_STEP, 4'h0, 4'hA, 4'h0, 8'h00), 1'b0, '0};
        dir_rows[15] = '{mk_item(CMD_RESTART, 4'hA, 4'h5, 4'hA, 8'h5A), 1'b1,
                         mk_result(8'h00, ST_OK, 4'h0)};

        // Hold reset, then release it on a falling edge
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        write_start_state('0);
        for (int i = 0; i < DIR_ROWS; i++)
            send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);

        // Random phases, each behind a drained pipeline and a new start state
        for (int p = 0; p < PHASES; p++) begin
            drain_results();
            case (p)
                0, 4:    write_start_state(4'hF);
                2:       write_start_state(4'h0);
                default: write_start_state(4'($urandom_range(15)));
            endcase
            idle_on = (p != 2);
            for (int n = 0; n < PHASE_ITEMS; n++) send_item(rand_item(), 1'b0, '0);
        end

        drain_results();
        repeat (6) @(posedge clk);
        $display("covered %0d items, %0d results, %0d start-state writes", items_sent,
                 results_seen, cfg_writes);
        $display("status mix: ok %0d, no-transition state %0d, missing symbol %0d",
                 status_cnt[ST_OK], status_cnt[ST_NO_STATE], status_cnt[ST_NO_SYMBOL]);
        if (mismatch_cnt == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

>>> table_driven_mealy_fsm.f
sv/tdmf_pkg.sv
sv/tdmf_ctrl.sv
sv/tdmf_dp.sv
sv/table_driven_mealy_fsm.sv
dv/table_driven_mealy_fsm_tb.sv
